>>> design/hsl_pkg.sv
// shared types and constants for the hsl to rgb converter
package hsl_pkg;

  // hue constants in 1/64 degree units
  localparam logic [14:0] HUE_FULL = 15'd23040;
  localparam logic [12:0] HUE_60   = 13'd3840;
  localparam logic [12:0] HUE_120  = 13'd7680;
  localparam logic [14:0] HUE_180  = 15'd11520;
  localparam logic [14:0] HUE_240  = 15'd15360;
  localparam logic [14:0] HUE_300  = 15'd19200;

  // fraction one in 1/256 units
  localparam logic [8:0] FRAC_ONE = 9'd256;

  // chroma at full scale, 1.0 with 17 fraction bits
  localparam logic [17:0] FIX_ONE = 18'd131072;

  // reciprocal of 15 scaled by 2^25, rounded down
  localparam logic [21:0] RECIP_15    = 22'd2236962;
  localparam int          RECIP_SHIFT = 25;

  // 60 degree hue sector
  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  // word between chroma and ramp stages
  typedef struct packed {
    logic        vld;
    logic [17:0] c17;
    logic [11:0] k;
    logic [8:0]  lit;
    sector_t     sector;
  } chroma_word_t;

  // word between ramp and channel stages
  typedef struct packed {
    logic        vld;
    logic [17:0] c17;
    logic [17:0] x17;
    logic [17:0] m17;
    sector_t     sector;
  } ramp_word_t;

endpackage

>>> design/hsl_chroma.sv
// input normalize, hue sector and ramp, chroma multiply (three stages)
module hsl_chroma (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [14:0]          in_hue,
  input  logic [8:0]           in_sat,
  input  logic [8:0]           in_lit,
  output hsl_pkg::chroma_word_t out_word
);

  // stage 1 registers
  logic        s1_vld_r;
  logic [14:0] s1_hue_r;
  logic [8:0]  s1_sat_r;
  logic [8:0]  s1_lit_r;
  logic [14:0] s1_hue_nxt;
  logic [8:0]  s1_sat_nxt;
  logic [8:0]  s1_lit_nxt;

  // stage 2 registers
  logic             s2_vld_r;
  logic [8:0]       s2_span_r;
  logic [8:0]       s2_sat_r;
  logic [8:0]       s2_lit_r;
  logic [11:0]      s2_k_r;
  hsl_pkg::sector_t s2_sec_r;
  logic [9:0]       two_l;
  logic [8:0]       lit_dev;
  logic [8:0]       s2_span_nxt;
  logic [12:0]      hm;
  logic [11:0]      s2_k_nxt;
  hsl_pkg::sector_t s2_sec_nxt;

  // stage 3 registers
  hsl_pkg::chroma_word_t s3_r;
  logic [16:0]           prod_cs;

  // wrap hue and saturate fractions
  always_comb begin
    s1_hue_nxt = (in_hue >= hsl_pkg::HUE_FULL) ? in_hue - hsl_pkg::HUE_FULL : in_hue;
    s1_sat_nxt = (in_sat > hsl_pkg::FRAC_ONE) ? hsl_pkg::FRAC_ONE : in_sat;
    s1_lit_nxt = (in_lit > hsl_pkg::FRAC_ONE) ? hsl_pkg::FRAC_ONE : in_lit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hue_r <= s1_hue_nxt;
      s1_sat_r <= s1_sat_nxt;
      s1_lit_r <= s1_lit_nxt;
    end
  end

  // lightness span 1 - |2l - 1|
  always_comb begin
    two_l = {s1_lit_r, 1'b0};
    if (two_l >= {1'b0, hsl_pkg::FRAC_ONE}) begin
      lit_dev = 9'(two_l - {1'b0, hsl_pkg::FRAC_ONE});
    end else begin
      lit_dev = 9'({1'b0, hsl_pkg::FRAC_ONE} - two_l);
    end
    s2_span_nxt = hsl_pkg::FRAC_ONE - lit_dev;
  end

  // hue inside a 120 degree period, triangle ramp and sector
  always_comb begin
    if (s1_hue_r < {2'b00, hsl_pkg::HUE_120}) begin
      hm = s1_hue_r[12:0];
    end else if (s1_hue_r < hsl_pkg::HUE_240) begin
      hm = 13'(s1_hue_r - {2'b00, hsl_pkg::HUE_120});
    end else begin
      hm = 13'(s1_hue_r - hsl_pkg::HUE_240);
    end
    if (hm >= hsl_pkg::HUE_60) begin
      s2_k_nxt = 12'(hsl_pkg::HUE_120 - hm);
    end else begin
      s2_k_nxt = hm[11:0];
    end
    if (s1_hue_r < {2'b00, hsl_pkg::HUE_60}) begin
      s2_sec_nxt = hsl_pkg::SEC_RED_YEL;
    end else if (s1_hue_r < {2'b00, hsl_pkg::HUE_120}) begin
      s2_sec_nxt = hsl_pkg::SEC_YEL_GRN;
    end else if (s1_hue_r < hsl_pkg::HUE_180) begin
      s2_sec_nxt = hsl_pkg::SEC_GRN_CYN;
    end else if (s1_hue_r < hsl_pkg::HUE_240) begin
      s2_sec_nxt = hsl_pkg::SEC_CYN_BLU;
    end else if (s1_hue_r < hsl_pkg::HUE_300) begin
      s2_sec_nxt = hsl_pkg::SEC_BLU_MAG;
    end else begin
      s2_sec_nxt = hsl_pkg::SEC_MAG_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_span_r <= s2_span_nxt;
      s2_sat_r  <= s1_sat_r;
      s2_lit_r  <= s1_lit_r;
      s2_k_r    <= s2_k_nxt;
      s2_sec_r  <= s2_sec_nxt;
    end
  end

  // chroma = span * s, doubled to 17 fraction bits
  assign prod_cs = 17'(s2_span_r * s2_sat_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else if (en) begin
      s3_r.vld <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.c17    <= {prod_cs, 1'b0};
      s3_r.k      <= s2_k_r;
      s3_r.lit    <= s2_lit_r;
      s3_r.sector <= s2_sec_r;
    end
  end

  assign out_word = s3_r;

`ifndef SYNTHESIS
  // ramp never exceeds one sector width
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_k_r <= 12'(hsl_pkg::HUE_60)))
    else $error("hue ramp above 60 degrees");

  // chroma never exceeds one
  a_c_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_r.vld |-> (s3_r.c17 <= hsl_pkg::FIX_ONE))
    else $error("chroma above one");
`endif

endmodule

>>> design/hsl_ramp.sv
// x = c * k / 3840 through a reciprocal multiply and correction, plus m (three stages)
module hsl_ramp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  hsl_pkg::chroma_word_t in_word,
  output hsl_pkg::ramp_word_t   out_word
);

  // stage 4: product c * k, quotient by 256, m
  logic             s4_vld_r;
  logic [20:0]      s4_q_r;
  logic [17:0]      s4_c_r;
  logic [17:0]      s4_m_r;
  hsl_pkg::sector_t s4_sec_r;
  logic [28:0]      prod_ck;
  logic [17:0]      l_fix;
  logic [17:0]      half_c;
  logic [17:0]      s4_m_nxt;

  // stage 5: estimate of q / 15
  logic             s5_vld_r;
  logic [20:0]      s5_q_r;
  logic [17:0]      s5_est_r;
  logic [17:0]      s5_c_r;
  logic [17:0]      s5_m_r;
  hsl_pkg::sector_t s5_sec_r;
  logic [42:0]      prod_rc;

  // stage 6: correction
  hsl_pkg::ramp_word_t s6_r;
  logic [21:0]         est_x15;
  logic [21:0]         rem;
  logic [17:0]         s6_x_nxt;

  assign prod_ck = 29'(in_word.c17 * in_word.k);
  assign l_fix   = {in_word.lit, 9'b0};
  assign half_c  = {1'b0, in_word.c17[17:1]};

  always_comb begin
    s4_m_nxt = (l_fix >= half_c) ? l_fix - half_c : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= in_word.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_q_r   <= prod_ck[28:8];
      s4_c_r   <= in_word.c17;
      s4_m_r   <= s4_m_nxt;
      s4_sec_r <= in_word.sector;
    end
  end

  // reciprocal multiply, estimate is exact or one low
  assign prod_rc = 43'(s4_q_r * hsl_pkg::RECIP_15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_q_r   <= s4_q_r;
      s5_est_r <= prod_rc[hsl_pkg::RECIP_SHIFT +: 18];
      s5_c_r   <= s4_c_r;
      s5_m_r   <= s4_m_r;
      s5_sec_r <= s4_sec_r;
    end
  end

  // remainder check, bump the estimate when it reaches 15
  always_comb begin
    est_x15  = {s5_est_r, 4'b0} - {4'b0, s5_est_r};
    rem      = {1'b0, s5_q_r} - est_x15;
    s6_x_nxt = (rem >= 22'd15) ? s5_est_r + 18'd1 : s5_est_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_r.vld <= 1'b0;
    end else if (en) begin
      s6_r.vld <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_r.c17    <= s5_c_r;
      s6_r.x17    <= s6_x_nxt;
      s6_r.m17    <= s5_m_r;
      s6_r.sector <= s5_sec_r;
    end
  end

  assign out_word = s6_r;

`ifndef SYNTHESIS
  // reciprocal estimate is never more than one low
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r |-> (rem < 22'd30))
    else $error("reciprocal estimate off by more than one");

  // x never exceeds chroma
  a_x_le_c: assert property (@(posedge clk) disable iff (!rst_n)
    s6_r.vld |-> (s6_r.x17 <= s6_r.c17))
    else $error("x above chroma");
`endif

endmodule

>>> design/hsl_mix.sv
// sector placement, add m, scale by 255, clamp, output register
module hsl_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  hsl_pkg::ramp_word_t in_word,
  output logic                out_vld,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue
);

  logic        vld_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [17:0] v_red;
  logic [17:0] v_green;
  logic [17:0] v_blue;

  // (v + m) * 255 >> 17, clamped to 255
  function automatic logic [7:0] chan_scale(input logic [17:0] v, input logic [17:0] m);
    logic [18:0] sum;
    logic [26:0] scaled;
    sum    = {1'b0, v} + {1'b0, m};
    scaled = {sum, 8'b0} - {8'b0, sum};
    return (scaled[26:17] > 10'd255) ? 8'd255 : scaled[24:17];
  endfunction

  // place c and x by sector
  always_comb begin
    case (in_word.sector)
      hsl_pkg::SEC_RED_YEL: begin
        v_red = in_word.c17; v_green = in_word.x17; v_blue = '0;
      end
      hsl_pkg::SEC_YEL_GRN: begin
        v_red = in_word.x17; v_green = in_word.c17; v_blue = '0;
      end
      hsl_pkg::SEC_GRN_CYN: begin
        v_red = '0; v_green = in_word.c17; v_blue = in_word.x17;
      end
      hsl_pkg::SEC_CYN_BLU: begin
        v_red = '0; v_green = in_word.x17; v_blue = in_word.c17;
      end
      hsl_pkg::SEC_BLU_MAG: begin
        v_red = in_word.x17; v_green = '0; v_blue = in_word.c17;
      end
      default: begin
        v_red = in_word.c17; v_green = '0; v_blue = in_word.x17;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_word.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= chan_scale(v_red, in_word.m17);
      green_r <= chan_scale(v_green, in_word.m17);
      blue_r  <= chan_scale(v_blue, in_word.m17);
    end
  end

  assign out_vld   = vld_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

>>> design/hsl_to_rgb_converter_unit.sv
// hsl to rgb converter top level: seven stage pipeline with shared stall
//
//   channel | ports                                   | direction
//   input   | in_valid in_ready in_hue in_saturation  | into block
//           | in_lightness                            |
//   result  | out_valid out_ready out_red out_green   | out of block
//           | out_blue                                |
//
// one word per cycle sustained while result words are taken
// stages in order: normalize, ramp, chroma mult, c*k mult,
// reciprocal mult, correction, channel scale into the output register
// all stages advance together whenever the output register is empty or taken
// in_ready is low only while a result word waits and out_ready is low
// reset clears the valid bits of every stage
module hsl_to_rgb_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [14:0] in_hue,
  input  logic [8:0]  in_saturation,
  input  logic [8:0]  in_lightness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  logic                  en;
  hsl_pkg::chroma_word_t chroma_word;
  hsl_pkg::ramp_word_t   ramp_word;

  // pipeline moves unless the result word is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  hsl_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_hue   (in_hue),
    .in_sat   (in_saturation),
    .in_lit   (in_lightness),
    .out_word (chroma_word)
  );

  hsl_ramp u_ramp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_word  (chroma_word),
    .out_word (ramp_word)
  );

  hsl_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_word   (ramp_word),
    .out_vld   (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

`ifndef SYNTHESIS
  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word valid after reset");

  // a held result word freezes the last ramp stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(ramp_word))
    else $error("pipeline moved during stall");
`endif

endmodule
